// File: design/fcl_pkg.sv
`default_nettype none

package fcl_pkg;

   // Array sizes of the layer.
   localparam int MAX_INPUTS  = 64;
   localparam int MAX_OUTPUTS = 64;

   // Index widths that follow from the sizes.
   localparam int IN_IDX_W  = $clog2(MAX_INPUTS);
   localparam int OUT_IDX_W = $clog2(MAX_OUTPUTS);
   localparam int WT_DEPTH  = MAX_INPUTS * MAX_OUTPUTS;

   // Field widths.
   localparam int CMD_W     = 2;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int CNT_W     = 7;
   localparam int VAL_W     = 32;
   localparam int ACC_W     = 64;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // Input item commands.
   localparam logic [CMD_W-1:0] CMD_WRITE_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_BIAS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FEED         = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_ENABLE  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 wt_we;
      logic                 bias_we;
      logic                 load_elem;
      logic                 mac_issue;
      logic                 seed;
      logic                 bias_en;
      logic                 emit_load;
      logic                 last;
      logic [IN_IDX_W-1:0]  elem;
      logic [OUT_IDX_W-1:0] col;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/fcl_ram.sv
`default_nettype none

module fcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/fcl_ctrl.sv
`default_nettype none

module fcl_ctrl
   import fcl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [CMD_W-1:0]     req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_data,
   output dp_cmd_type                dp_cmd,
   input  wire dp_status_type        dp_status
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_MAC       = 6'b000010,
      ST_DRAIN     = 6'b000100,
      ST_EMIT_RD   = 6'b001000,
      ST_EMIT_WAIT = 6'b010000,
      ST_EMIT_HOLD = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [OUT_IDX_W-1:0] col_ff, col_in;
   logic [IN_IDX_W-1:0]  elem_ff, elem_in;
   logic [CNT_W-1:0]     input_count_ff, output_count_ff;
   logic                 bias_enable_ff;
   logic [CNT_W-1:0]     n_in, n_out;
   logic                 vec_end, col_last, out_last, req_acc;

   // Counts of zero act as one, counts above the array size saturate.
   always_comb begin
      if (input_count_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (input_count_ff > CNT_W'(MAX_INPUTS)) begin
         n_in = CNT_W'(MAX_INPUTS);
      end else begin
         n_in = input_count_ff;
      end
      if (output_count_ff == '0) begin
         n_out = CNT_W'(1);
      end else if (output_count_ff > CNT_W'(MAX_OUTPUTS)) begin
         n_out = CNT_W'(MAX_OUTPUTS);
      end else begin
         n_out = output_count_ff;
      end
   end

   assign vec_end  = (CNT_W'(elem_ff) + CNT_W'(1)) >= n_in;
   assign col_last = col_ff == OUT_IDX_W'(MAX_OUTPUTS - 1);
   assign out_last = (CNT_W'(col_ff) + CNT_W'(1)) == n_out;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_EMIT_HOLD;
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      dp_cmd.wt_we     = req_acc && (req_tuser == CMD_WRITE_WEIGHT);
      dp_cmd.bias_we   = req_acc && (req_tuser == CMD_WRITE_BIAS);
      dp_cmd.load_elem = req_acc && (req_tuser == CMD_FEED);
      dp_cmd.mac_issue = state_ff == ST_MAC;
      dp_cmd.seed      = elem_ff == '0;
      dp_cmd.bias_en   = bias_enable_ff;
      dp_cmd.emit_load = state_ff == ST_EMIT_WAIT;
      dp_cmd.last      = out_last;
      dp_cmd.elem      = elem_ff;
      dp_cmd.col       = col_ff;
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      elem_in  = elem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == CMD_FEED)) begin
               col_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (col_last) begin
               col_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + OUT_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // Wait until the last accumulator write has landed.
            if (!dp_status.pipe_busy) begin
               if (vec_end) begin
                  elem_in  = '0;
                  col_in   = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  elem_in  = elem_ff + IN_IDX_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            state_in = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_tready) begin
               if (out_last) begin
                  col_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + OUT_IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         col_ff          <= '0;
         elem_ff         <= '0;
         input_count_ff  <= CNT_W'(64);
         output_count_ff <= CNT_W'(64);
         bias_enable_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         elem_ff  <= elem_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INPUT_COUNT:  input_count_ff  <= csr_data;
               REG_OUTPUT_COUNT: output_count_ff <= csr_data;
               REG_BIAS_ENABLE:  bias_enable_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// File: design/fcl_datapath.sv
`default_nettype none

module fcl_datapath
   import fcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   input  wire dp_cmd_type            dp_cmd,
   output dp_status_type              dp_status
);

   localparam int SEED_EXT_W = ACC_W - VAL_W - FRAC_W;
   localparam int Q_W        = ACC_W - FRAC_W;
   localparam int RND_W      = Q_W + 1;

   logic [ROW_W-1:0]  req_row;
   logic [COL_W-1:0]  req_col;
   logic [VAL_W-1:0]  req_value;

   logic signed [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0]        wt_rd, bias_rd;
   logic [ACC_W-1:0]        acc_rd;

   logic                    s1_valid_ff, s2_valid_ff;
   logic [OUT_IDX_W-1:0]    s1_col_ff, s2_col_ff;
   logic                    s1_seed_ff, s1_bias_en_ff;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] base_ff, base_in;
   logic [ACC_W:0]          sum_wide;
   logic [ACC_W-1:0]        sum_sat;

   logic [RND_W-1:0]        rnd;
   logic [VAL_W-1:0]        rnd_sat;
   logic [OUT_IDX_W-1:0]    out_index_ff;
   logic [VAL_W-1:0]        out_value_ff;
   logic                    out_last_ff;

   assign req_row   = req_tdata[ROW_W-1:0];
   assign req_col   = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_value = req_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];

   fcl_ram #(.WIDTH(VAL_W), .DEPTH(WT_DEPTH)) u_wt_ram (
      .clock (clock),
      .we    (dp_cmd.wt_we),
      .waddr ({req_row[IN_IDX_W-1:0], req_col[OUT_IDX_W-1:0]}),
      .wdata (req_value),
      .raddr ({dp_cmd.elem, dp_cmd.col}),
      .rdata (wt_rd)
   );

   fcl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
      .clock (clock),
      .we    (dp_cmd.bias_we),
      .waddr (req_col[OUT_IDX_W-1:0]),
      .wdata (req_value),
      .raddr (dp_cmd.col),
      .rdata (bias_rd)
   );

   fcl_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUTPUTS)) u_acc_ram (
      .clock (clock),
      .we    (s2_valid_ff),
      .waddr (s2_col_ff),
      .wdata (sum_sat),
      .raddr (dp_cmd.col),
      .rdata (acc_rd)
   );

   // Stage 1: weight, bias and accumulator reads are back; form the product
   // and the addend base (bias seed, zero seed or running sum).
   assign prod_in = ACC_W'(value_ff) * ACC_W'($signed(wt_rd));

   always_comb begin
      if (s1_seed_ff) begin
         if (s1_bias_en_ff) begin
            base_in = {{SEED_EXT_W{bias_rd[VAL_W-1]}}, bias_rd, FRAC_W'(0)};
         end else begin
            base_in = '0;
         end
      end else begin
         base_in = acc_rd;
      end
   end

   // Stage 2: saturating add and accumulator write-back.
   assign sum_wide = {base_ff[ACC_W-1], base_ff} + {prod_ff[ACC_W-1], prod_ff};

   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                   : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
   end

   // Round to nearest with ties upward, then saturate to 32 bits.
   assign rnd = {acc_rd[ACC_W-1], acc_rd[ACC_W-1:FRAC_W]} + RND_W'(acc_rd[FRAC_W-1]);

   always_comb begin
      if (!rnd[RND_W-1] && (|rnd[RND_W-2:VAL_W-1])) begin
         rnd_sat = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (rnd[RND_W-1] && !(&rnd[RND_W-2:VAL_W-1])) begin
         rnd_sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         rnd_sat = rnd[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= dp_cmd.mac_issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_elem) begin
         value_ff <= $signed(req_value);
      end
      s1_col_ff     <= dp_cmd.col;
      s1_seed_ff    <= dp_cmd.seed;
      s1_bias_en_ff <= dp_cmd.bias_en;
      s2_col_ff     <= s1_col_ff;
      prod_ff       <= prod_in;
      base_ff       <= base_in;
      if (dp_cmd.emit_load) begin
         out_index_ff <= dp_cmd.col;
         out_value_ff <= rnd_sat;
         out_last_ff  <= dp_cmd.last;
      end
   end

   assign dp_status.pipe_busy = s1_valid_ff || s2_valid_ff;

   assign rsp_tdata = {(RSP_DATA_W-VAL_W-OUT_IDX_W)'(0), out_value_ff, out_index_ff};
   assign rsp_tlast = out_last_ff;

endmodule

`default_nettype wire

// File: design/fully_connected_layer.sv
// Dense layer: streaming matrix-vector multiply with bias, signed Q16.16.
//
// Channels: req_ carries input items. req_tuser is the command (write weight,
// write bias, feed element); req_tdata packs row, column and value. rsp_
// carries one result item per output feature in column order, rsp_tlast set
// on the final one. csr_ writes input_count, output_count and bias_enable.
//
// Weight and bias writes are taken in the idle state and leave the block idle.
// A fed element runs one multiply-accumulate per cycle on the shared multiplier
// through all 64 accumulators in a three-stage pipeline (RAM read, multiply,
// saturating add and write-back). After the last element of a vector the
// outputs follow, each through three steps (accumulator read, round and
// saturate, present). req_tready is low from a fed element until its work
// and any results are done.
//
// Reset returns the registers to 64, 64 and 1 and restarts the element count;
// weight, bias and accumulator memories are not cleared and need no sweep.
// When the receiver stalls, the current result holds on rsp_ until taken.
`default_nettype none

module fully_connected_layer
   import fcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input items.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // row[5:0], column[11:6], value[43:12]
   input  wire logic [CMD_W-1:0]      req_tuser,  // command[1:0]
   // Result items.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,  // out_index[5:0], out_value[37:6]
   output logic                       rsp_tlast,
   // Configuration writes.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CNT_W-1:0]      csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller sequences elements and results and holds the registers.
   fcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   // The datapath owns the memories, the MAC pipeline and the output register.
   fcl_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

endmodule

`default_nettype wire

// File: design/fcl_checker.sv
`default_nettype none

module fcl_checker
   import fcl_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Input items are never taken while a result is on offer.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted during result phase");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result offered after reset");

   // After the final result the block returns to taking input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block did not return to idle after final result");

   // Between results of one vector no input is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("input accepted in the middle of a result run");

endmodule

bind fully_connected_layer fcl_checker u_fcl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: bench/tb_fully_connected_layer.sv
module tb_fully_connected_layer;
   timeunit 1ns;
   timeprecision 1ps;
   import fcl_pkg::*;

   // Bench timing. The settle time after the last output covers one element
   // with room to spare.
   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 160;
   localparam int DRAIN_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 40;

   // Weight rows the bench loads. Element counts never go beyond them, so no
   // element reads a row that was never written.
   localparam int USED_ROWS = 3;

   // Random part: phases of counted items, each phase with its own settings.
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 12;

   // Codes the package leaves unnamed: the spare command and register index.
   localparam logic [CMD_W-1:0]     CMD_RESERVED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] value;
   } layer_cmd_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] index;
      logic [VAL_W-1:0]     value;
      logic                 last;
   } layer_out_type;

   // Every input of the block starts at a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // row[5:0], column[11:6], value[43:12]
   logic [CMD_W-1:0]      req_tuser  = '0;  // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_index[5:0], out_value[37:6]
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CNT_W-1:0]      csr_data   = '0;

   // Shadow copy of the layer: tables, accumulators, element position and the
   // three registers, all updated at the handshakes that change the block.
   int               weight_tab [WT_DEPTH];
   int               bias_tab   [MAX_OUTPUTS];
   longint           acc_tab    [MAX_OUTPUTS];
   int               elem_count;
   logic [CNT_W-1:0] in_count_reg;
   logic [CNT_W-1:0] out_count_reg;
   logic             bias_on_reg;

   layer_cmd_type pending_cmds[$];      // items the driver still has to send
   layer_out_type expected_outputs[$];  // outputs predicted but not yet seen
   layer_cmd_type cmd_on_bus;           // item currently offered on req_
   bit            cmd_presented = 1'b0;
   bit            csr_pending   = 1'b0;
   int            send_idle_pct = 13;
   int            recv_idle_pct = 65;
   int            mismatch_count = 0;

   fully_connected_layer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // A count of zero behaves as one and anything above the table size is
   // clipped to it.
   function automatic int clamp_count(logic [CNT_W-1:0] n, int top);
      if (n == 0) return 1;
      return (n > top) ? top : int'(n);
   endfunction

   // Signed 64-bit add that sticks at the bounds instead of wrapping.
   function automatic longint sat_add64(longint a, longint b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1])
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return s[ACC_W-1:0];
   endfunction

   // Q32.32 to Q16.16: round to nearest with ties going up, then clip to the
   // signed 32-bit range.
   function automatic logic [VAL_W-1:0] round_q16(longint a);
      longint q;
      q = (a >>> FRAC_W) + longint'(a[FRAC_W-1]);
      if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -64'sd2147483648) return 32'h8000_0000;
      return q[VAL_W-1:0];
   endfunction

   // Advances the shadow layer by one accepted item and queues the outputs
   // that item releases.
   task automatic apply_layer_cmd(input layer_cmd_type c);
      int            n_in;
      int            n_out;
      int            x;
      layer_out_type r;
      x = $signed(c.value);
      case (c.cmd)
         CMD_WRITE_WEIGHT: weight_tab[c.row * MAX_OUTPUTS + c.col] = x;
         CMD_WRITE_BIAS:   bias_tab[c.col] = x;
         CMD_FEED: begin
            n_in  = clamp_count(in_count_reg, MAX_INPUTS);
            n_out = clamp_count(out_count_reg, MAX_OUTPUTS);
            if (elem_count >= MAX_INPUTS) elem_count = 0;
            // The first element of a vector seeds every accumulator, all of
            // them and not only the ones that will be emitted.
            if (elem_count == 0) begin
               foreach (acc_tab[j])
                  acc_tab[j] = bias_on_reg ? longint'(bias_tab[j]) <<< FRAC_W : 64'sd0;
            end
            foreach (acc_tab[j])
               acc_tab[j] = sat_add64(acc_tab[j],
                  longint'(x) * longint'(weight_tab[elem_count * MAX_OUTPUTS + j]));
            elem_count++;
            if (elem_count >= n_in) begin
               elem_count = 0;
               for (int k = 0; k < n_out; k++) begin
                  r.index = k[OUT_IDX_W-1:0];
                  r.value = round_q16(acc_tab[k]);
                  r.last  = (k == n_out - 1);
                  expected_outputs.push_back(r);
               end
            end
         end
         default: ;  // the spare command does nothing
      endcase
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t error: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void push_cmd(logic [CMD_W-1:0] cmd, int row, int col,
                                    logic [VAL_W-1:0] value);
      layer_cmd_type c;
      c.cmd   = cmd;
      c.row   = ROW_W'(row);
      c.col   = COL_W'(col);
      c.value = value;
      pending_cmds.push_back(c);
   endfunction

   // Q16.16 values: mostly within a few units so that sums stay readable,
   // some full-width words, and now and then one of the corner values.
   function automatic logic [VAL_W-1:0] rand_q16(int wide_pct);
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_8000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      if (pick < 4 + wide_pct) return $urandom();
      return VAL_W'(int'($urandom_range(524287)) - 262144);
   endfunction

   // One register write. It starts at a falling edge and returns at the
   // falling edge after the write was taken, leaving csr_valid high so that
   // back-to-back writes never lower and raise it in the same step.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
      csr_index   <= idx;
      csr_data    <= data;
      csr_valid   <= 1'b1;
      csr_pending = 1'b1;
      do @(negedge clock); while (csr_pending);
   endtask

   task automatic program_layer(input logic [CNT_W-1:0] n_in, n_out, bias_word);
      @(negedge clock);
      csr_put(REG_INPUT_COUNT, n_in);
      csr_put(REG_OUTPUT_COUNT, n_out);
      csr_put(REG_BIAS_ENABLE, bias_word);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender back until every queued item went out and every
   // predicted output came back, then lets a fed element that releases no
   // output finish inside the block before anything else happens.
   task automatic wait_drained();
      int waited;
      waited = 0;
      while ((pending_cmds.size() > 0 || cmd_presented || expected_outputs.size() > 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (waited >= DRAIN_LIMIT)
         report_mismatch($sformatf("stalled with %0d items unsent and %0d outputs missing",
                                   pending_cmds.size() + cmd_presented,
                                   expected_outputs.size()));
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Driver. Inputs move on the falling edge. An offered item stays on the
   // bus until the monitor saw it taken; the receiver's ready is redrawn
   // every cycle from its idle rate.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid    <= 1'b0;
         rsp_tready    <= 1'b0;
         cmd_presented = 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (!cmd_presented) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cmd_on_bus    = pending_cmds.pop_front();
               cmd_presented = 1'b1;
               req_tvalid    <= 1'b1;
               req_tdata     <= REQ_DATA_W'({cmd_on_bus.value, cmd_on_bus.col,
                                             cmd_on_bus.row});
               req_tuser     <= cmd_on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Handshakes are sampled on the rising edge, where every input
   // has been stable for half a period. Accepted items drive the shadow
   // layer, accepted outputs are checked against the oldest prediction, and
   // register writes update the shadow registers.
   always @(posedge clock) begin : monitor
      layer_out_type want;
      if (reset) begin
         elem_count    = 0;
         in_count_reg  = 7'd64;
         out_count_reg = 7'd64;
         bias_on_reg   = 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_layer_cmd(cmd_on_bus);
            cmd_presented = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch($sformatf("output item with index %0d arrived unpredicted",
                                         rsp_tdata[OUT_IDX_W-1:0]));
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_tdata[OUT_IDX_W-1:0] !== want.index)
                  report_mismatch($sformatf("out_index %0d, predicted %0d",
                                            rsp_tdata[OUT_IDX_W-1:0], want.index));
               if (rsp_tdata[OUT_IDX_W +: VAL_W] !== want.value)
                  report_mismatch($sformatf("out_value %0d at index %0d, predicted %0d",
                                            $signed(rsp_tdata[OUT_IDX_W +: VAL_W]),
                                            want.index, $signed(want.value)));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %b at index %0d, predicted %b",
                                            rsp_tlast, want.index, want.last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INPUT_COUNT:  in_count_reg  = csr_data;
               REG_OUTPUT_COUNT: out_count_reg = csr_data;
               REG_BIAS_ENABLE:  bias_on_reg   = csr_data[0];
               default: ;
            endcase
            csr_pending = 1'b0;
         end
      end
   end

   // Stimulus.
   initial begin : stimulus
      int               pick;
      int               counted;
      logic [CNT_W-1:0] n_in;
      logic [CNT_W-1:0] n_out;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // The block is idle straight out of reset: two elements per vector and
      // four outputs for the hand-picked vectors below.
      program_layer(7'd2, 7'd4, 7'd1);

      // Load the weight rows that elements will reach and every bias first.
      // Element counts stay within those rows and a seed reads all biases, so
      // from here on no entry can be read before it was written.
      for (int r = 0; r < USED_ROWS; r++)
         for (int c = 0; c < MAX_OUTPUTS; c++)
            push_cmd(CMD_WRITE_WEIGHT, r, c, rand_q16(3));
      for (int c = 0; c < MAX_OUTPUTS; c++)
         push_cmd(CMD_WRITE_BIAS, 0, c, rand_q16(3));

      // Hand-picked corner cases. Column 0 sees a rounding tie on each side
      // of zero, column 2 drives the accumulator past its negative bound and
      // column 3 past its positive one, column 1 clips at the output.
      push_cmd(CMD_WRITE_WEIGHT, 0, 0, 32'h0000_0001);
      push_cmd(CMD_WRITE_WEIGHT, 0, 1, 32'h7FFF_FFFF);
      push_cmd(CMD_WRITE_WEIGHT, 0, 2, 32'h7FFF_FFFF);
      push_cmd(CMD_WRITE_WEIGHT, 0, 3, 32'h8000_0000);
      push_cmd(CMD_WRITE_WEIGHT, 1, 0, 32'hFFFF_FFFF);
      push_cmd(CMD_WRITE_WEIGHT, 1, 1, 32'h7FFF_FFFF);
      push_cmd(CMD_WRITE_WEIGHT, 1, 2, 32'h7FFF_FFFF);
      push_cmd(CMD_WRITE_WEIGHT, 1, 3, 32'h8000_0000);
      push_cmd(CMD_WRITE_BIAS, 0, 0, 32'h0000_0000);
      push_cmd(CMD_WRITE_BIAS, 0, 1, 32'h7FFF_FFFF);
      push_cmd(CMD_WRITE_BIAS, 0, 2, 32'h8000_0000);
      push_cmd(CMD_WRITE_BIAS, 0, 3, 32'h0001_8000);
      push_cmd(CMD_WRITE_WEIGHT, 63, 63, 32'h8000_0000);
      push_cmd(CMD_WRITE_BIAS, 63, 63, 32'h7FFF_FFFF);
      push_cmd(CMD_RESERVED, 63, 63, 32'hFFFF_FFFF);
      push_cmd(CMD_FEED, 0, 0, 32'h0000_8000);
      push_cmd(CMD_FEED, 63, 63, 32'h0000_0000);
      push_cmd(CMD_FEED, 0, 0, 32'h0000_0000);
      push_cmd(CMD_FEED, 0, 0, 32'h0000_8000);
      push_cmd(CMD_FEED, 21, 42, 32'h8000_0000);
      push_cmd(CMD_FEED, 42, 21, 32'h8000_0000);
      wait_drained();

      // All 64 outputs with the bias switched off.
      program_layer(CNT_W'(USED_ROWS), 7'd64, 7'd0);
      for (int i = 0; i < USED_ROWS; i++)
         push_cmd(CMD_FEED, $urandom_range(63), $urandom_range(63), rand_q16(5));
      wait_drained();

      // Smallest layer; a write to the spare register index must change
      // nothing.
      program_layer(7'd1, 7'd1, 7'd3);
      @(negedge clock);
      csr_put(REG_UNUSED, 7'h2A);
      csr_valid <= 1'b0;
      for (int i = 0; i < 3; i++)
         push_cmd(CMD_FEED, 0, 0, rand_q16(20));
      wait_drained();

      // Zero counts act as one; bias off with the upper data bits set.
      program_layer(7'd0, 7'd0, 7'h7E);
      for (int i = 0; i < 3; i++)
         push_cmd(CMD_FEED, 0, 0, rand_q16(20));
      wait_drained();

      // An output count above the table size clips to it.
      program_layer(CNT_W'(USED_ROWS), 7'd100, 7'd1);
      for (int i = 0; i < USED_ROWS; i++)
         push_cmd(CMD_FEED, $urandom_range(63), $urandom_range(63), rand_q16(5));
      wait_drained();

      // Random phases. Each one picks new settings while the block is idle,
      // then streams mostly elements with table rewrites mixed in. Phases may
      // stop in the middle of a vector, so settings also change mid-vector.
      // Pacing: slow receiver first, then slow sender, then no idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 65;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n_in = CNT_W'($urandom_range(1, USED_ROWS));
         pick = $urandom_range(99);
         n_out = (pick < 45) ? CNT_W'($urandom_range(1, 8)) :
                 (pick < 80) ? CNT_W'($urandom_range(9, 63)) :
                               CNT_W'($urandom_range(64, 127));
         program_layer(n_in, n_out, CNT_W'($urandom_range(127)));

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 74) begin
               push_cmd(CMD_FEED, $urandom_range(63), $urandom_range(63), rand_q16(10));
            end else if (pick < 86) begin
               push_cmd(CMD_WRITE_WEIGHT, $urandom_range(63), $urandom_range(63),
                        rand_q16(5));
            end else if (pick < 96) begin
               push_cmd(CMD_WRITE_BIAS, $urandom_range(63), $urandom_range(63),
                        rand_q16(5));
            end else begin
               // Ignored by the block, so it does not count toward the phase.
               push_cmd(CMD_RESERVED, $urandom_range(63), $urandom_range(63), $urandom());
               continue;
            end
            counted++;
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #24ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
design/fcl_pkg.sv
design/fcl_ram.sv
design/fcl_ctrl.sv
design/fcl_datapath.sv
design/fully_connected_layer.sv
design/fcl_checker.sv
bench/tb_fully_connected_layer.sv
